### design/bole_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bole_pkg
// Shared types and codes for the bounded ordered list engine.
// ----------------------------------------------------------------------------
package bole_pkg;

  localparam int REQ_W   = 3;
  localparam int VAL_W   = 32;
  localparam int POS_W   = 8;
  localparam int STAT_W  = 2;
  localparam int ENTRY_W = 5;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INS_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INS_POS   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DEL_FRONT = 3'd3;
  localparam logic [REQ_W-1:0] REQ_WALK_FWD  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_WALK_BACK = 3'd5;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // input transfer this cycle
    logic step;    // emit next walk element into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic walk_multi;  // accepted request is a walk of more than one element
    logic step_last;   // next walk step is the final one
  } sts_t;

endpackage

### design/bounded_ordered_list_engine_core.sv
`timescale 1ns / 1ps
// Latency: a result is valid the cycle after its request transfer.
// Throughput: insert, delete and unused codes: one per cycle while out_ready is high.
// A walk gives one cell per cycle while out_ready is high; input waits for its end.
// Reset clears the fill count, the walk pointer and the output valid flag.
// Cell contents are not cleared; only cells below the count are ever read.
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine_core
// Ordered list of up to CAPACITY signed values with front/back/positional
// insert, front delete and forward/backward walks.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine_core
  import bole_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  // request channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [REQ_W-1:0]        req_type,
  input  logic signed [VAL_W-1:0] entry_value,
  input  logic [POS_W-1:0]        position,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] element_value,
  output logic                    last,
  output logic [STAT_W-1:0]       status,
  output logic signed [VAL_W-1:0] head_value,
  output logic signed [VAL_W-1:0] tail_value,
  output logic [ENTRY_W-1:0]      entry_count
);

  // Controller drives transfer and walk-step commands; the datapath
  // reports whether a walk needs more steps.
  cmd_t cmd;
  sts_t sts;

  // Handshake and walk sequencer. A new request is taken whenever the
  // controller is idle and the output register is empty or being drained,
  // so single-result requests run one per cycle.
  bole_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Cell array shifts in parallel on insert/delete. The first walk element
  // is produced at the request transfer (head cell or tail copy); the rest
  // follow one per step through the walk pointer.
  bole_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .req_type      (req_type),
    .entry_value   (entry_value),
    .position      (position),
    .element_value (element_value),
    .last          (last),
    .status        (status),
    .head_value    (head_value),
    .tail_value    (tail_value),
    .entry_count   (entry_count)
  );

endmodule

### design/bole_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bole_ctrl
// Handshake control and walk sequencing for the list engine.
// ----------------------------------------------------------------------------
module bole_ctrl
  import bole_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   slot_free;

  assign slot_free  = !out_valid || out_ready;
  assign in_ready   = (state == ST_IDLE) && slot_free;
  assign cmd.accept = in_valid && in_ready;
  assign cmd.step   = (state == ST_WALK) && slot_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.accept && sts.walk_multi) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (cmd.step && sts.step_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.accept || cmd.step) out_valid_next = 1'b1;
    else if (out_ready)         out_valid_next = 1'b0;
    else                        out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTH
  // A new result is only loaded when the output slot is free.
  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept || cmd.step) |-> (!out_valid || out_ready))
    else $error("result loaded over a pending result");

  // A walk ends only through its final step.
  a_walk_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) ##1 (state == ST_IDLE) |-> $past(cmd.step && sts.step_last))
    else $error("walk left without final step");

  // No input is taken while a walk is in progress.
  a_no_accept_walk: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> !cmd.accept)
    else $error("input accepted during walk");
`endif

endmodule

### design/bole_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bole_datapath
// Shifting cell array, fill count, tail copy, walk pointer and result regs.
// ----------------------------------------------------------------------------
module bole_datapath
  import bole_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  output sts_t                      sts,
  input  logic [REQ_W-1:0]          req_type,
  input  logic signed [VAL_W-1:0]   entry_value,
  input  logic [POS_W-1:0]          position,
  output logic signed [VAL_W-1:0]   element_value,
  output logic                      last,
  output logic [STAT_W-1:0]         status,
  output logic signed [VAL_W-1:0]   head_value,
  output logic signed [VAL_W-1:0]   tail_value,
  output logic [ENTRY_W-1:0]        entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  logic [VAL_W-1:0] cells      [CAPACITY];
  logic [VAL_W-1:0] cells_next [CAPACITY];
  logic [CW-1:0]    count, count_next;
  logic [VAL_W-1:0] tail;
  logic [IW-1:0]    walk_idx;
  logic [IW-1:0]    walk_left;
  logic             walk_back;

  logic             is_ins, is_del, is_walk, is_back;
  logic             full, empty;
  logic             do_ins, do_del;
  logic [IW-1:0]    ins_idx;
  logic [POS_W-1:0] count_p;

  assign is_ins  = (req_type == REQ_INS_FRONT) || (req_type == REQ_INS_BACK) ||
                   (req_type == REQ_INS_POS);
  assign is_del  = (req_type == REQ_DEL_FRONT);
  assign is_back = (req_type == REQ_WALK_BACK);
  assign is_walk = (req_type == REQ_WALK_FWD) || is_back;
  assign full    = (count == CW'(CAPACITY));
  assign empty   = (count == '0);
  assign do_ins  = cmd.accept && is_ins && !full;
  assign do_del  = cmd.accept && is_del && !empty;
  assign count_p = POS_W'(count);

  assign sts.walk_multi = is_walk && (count > CW'(1));
  assign sts.step_last  = (walk_left == IW'(1));

  // Insert slot, position clamped to 1 .. count+1
  always_comb begin
    if (req_type == REQ_INS_FRONT)   ins_idx = '0;
    else if (req_type == REQ_INS_BACK) ins_idx = IW'(count);
    else if (position == '0)         ins_idx = '0;
    else if (position > count_p)     ins_idx = IW'(count);
    else                             ins_idx = IW'(position - POS_W'(1));
  end

  // All cells shift in parallel: right of the slot on insert, left on delete
  always_comb begin
    cells_next = cells;
    if (do_ins) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (IW'(i) == ins_idx) cells_next[i] = entry_value;
      end
      for (int i = 1; i < CAPACITY; i++) begin
        if (IW'(i) > ins_idx) cells_next[i] = cells[i-1];
      end
    end else if (do_del) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        cells_next[i] = cells[i+1];
      end
    end
  end

  always_comb begin
    count_next = count;
    if (do_ins)      count_next = count + CW'(1);
    else if (do_del) count_next = count - CW'(1);
  end

  always_ff @(posedge clk) begin
    cells <= cells_next;
    if (do_ins && (ins_idx == IW'(count))) tail <= entry_value;
  end

  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else     count <= count_next;
  end

  // Result registers and walk pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_idx  <= '0;
      walk_left <= '0;
      walk_back <= 1'b0;
    end else if (cmd.accept && is_walk && !empty) begin
      walk_back <= is_back;
      walk_left <= IW'(count - CW'(1));
      walk_idx  <= is_back ? IW'(count - CW'(2)) : IW'(1);
    end else if (cmd.step) begin
      walk_left <= walk_left - IW'(1);
      walk_idx  <= walk_back ? walk_idx - IW'(1) : walk_idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      element_value <= '0;
      last          <= 1'b1;
      status        <= STAT_OK;
      if (is_ins) begin
        if (full) status <= STAT_FULL;
      end else if (is_del) begin
        if (empty) status <= STAT_EMPTY;
      end else if (is_walk) begin
        if (empty) begin
          status <= STAT_EMPTY;
        end else begin
          element_value <= is_back ? tail : cells[0];
          last          <= (count == CW'(1));
        end
      end
    end else if (cmd.step) begin
      element_value <= cells[walk_idx];
      last          <= (walk_left == IW'(1));
      status        <= STAT_OK;
    end
  end

  // State only changes on a transfer, so these track the pending result
  assign head_value  = empty ? '0 : cells[0];
  assign tail_value  = empty ? '0 : tail;
  assign entry_count = ENTRY_W'(count);

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("fill count beyond capacity");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(cmd.accept)) |-> (count == $past(count)))
    else $error("fill count changed without a transfer");

  a_step_left: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (walk_left != '0))
    else $error("walk step with nothing left");
`endif

endmodule
